[hdl/rtnh_pkg.sv]
package rtnh_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TAG_BITS_DEF   = 16;
    localparam int TOL_BITS       = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;

    typedef enum logic [2:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_DIR_X      = 3'd3,
        REG_DIR_Y      = 3'd4,
        REG_DIR_Z      = 3'd5,
        REG_SEGMENT    = 3'd6,
        REG_TOLERANCE  = 3'd7
    } reg_idx_t;

    // Datapath operation selected by the sequencer.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PROD_H,
        OP_CROSS_H,
        OP_PROD_DET,
        OP_DOT_DET,
        OP_PROD_Q,
        OP_CROSS_Q,
        OP_PROD_N,
        OP_DOT_N,
        OP_DIV_START,
        OP_KEEP,
        OP_PROD_P,
        OP_EMIT
    } dp_op_t;

    // Which quotient is being formed.
    typedef enum logic [1:0] {
        NUM_U,
        NUM_V,
        NUM_T
    } num_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PROD_H,
        ST_CROSS_H,
        ST_PROD_DET,
        ST_DOT_DET,
        ST_PROD_Q,
        ST_CROSS_Q,
        ST_PROD_N,
        ST_DOT_N,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_KEEP,
        ST_PROD_P,
        ST_EMIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        dp_op_t   op;
        num_sel_t num_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic det_ok;
        logic u_ok;
        logic v_ok;
        logic div_done;
    } dp_status_t;

endpackage

[hdl/rtnh_if.sv]
interface rtnh_tri_if #(
    parameter int COORD_BITS = rtnh_pkg::COORD_BITS_DEF,
    parameter int TAG_BITS   = rtnh_pkg::TAG_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic [TAG_BITS-1:0]          tri_tag;
    logic                         final_triangle;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    tri_tag, final_triangle, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  tri_tag, final_triangle, output ready);
endinterface

interface rtnh_hit_if #(
    parameter int COORD_BITS = rtnh_pkg::COORD_BITS_DEF,
    parameter int TAG_BITS   = rtnh_pkg::TAG_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic signed [COORD_BITS-1:0] nearest_t, point_x, point_y, point_z;
    logic [TAG_BITS-1:0]          nearest_tag;

    modport source (output valid, found, nearest_t, point_x, point_y, point_z,
                    nearest_tag, input ready);
    modport sink (input valid, found, nearest_t, point_x, point_y, point_z,
                  nearest_tag, output ready);
endinterface

interface rtnh_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rtnh_pkg::CFG_IDX_BITS-1:0]  index;
    logic [rtnh_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/rtnh_div.sv]
// Restoring divider: one quotient bit per cycle, saturating magnitude.
module rtnh_div #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] num,
    input  logic signed [COORD_BITS-1:0] den,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] quot
);
    localparam int STEPS   = COORD_BITS + FRAC_BITS;
    localparam int CNT_W   = $clog2(STEPS + 1);
    localparam int MAG_W   = COORD_BITS + 1;
    localparam int REM_W   = COORD_BITS + 2;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] den_reg, den_next;
    logic [STEPS-1:0] sh_reg, sh_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] q_reg, q_next;
    logic [MAG_W-1:0] num_mag, den_mag, cap;
    logic [REM_W-1:0] rem_sh;
    logic [MAG_W:0]   q_sh;

    assign cap     = MAG_W'(1) << (COORD_BITS - 1);
    assign num_mag = num[COORD_BITS-1] ? MAG_W'(-$signed({num[COORD_BITS-1], num}))
                                       : MAG_W'({1'b0, num});
    assign den_mag = den[COORD_BITS-1] ? MAG_W'(-$signed({den[COORD_BITS-1], den}))
                                       : MAG_W'({1'b0, den});
    assign rem_sh  = {rem_reg[REM_W-2:0], sh_reg[STEPS-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        q_sh      = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            neg_next  = num[COORD_BITS-1] ^ den[COORD_BITS-1];
            den_next  = den_mag;
            sh_next   = {num_mag[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            q_sh = {q_reg, 1'b0};
            if (rem_sh >= REM_W'(den_reg))
            begin
                rem_next = rem_sh - REM_W'(den_reg);
                q_sh[0]  = 1'b1;
            end
            else
            begin
                rem_next = rem_sh;
            end
            q_next  = (q_sh > (MAG_W+1)'(cap)) ? cap : q_sh[MAG_W-1:0];
            sh_next = {sh_reg[STEPS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    logic [MAG_W-1:0] qlim;
    always_comb
    begin
        qlim = (!neg_reg && q_reg > MAG_W'(cap - 1'b1)) ? cap - 1'b1 : q_reg;
        quot = neg_reg ? COORD_BITS'(-$signed(qlim)) : COORD_BITS'(qlim);
    end

    assign done = !busy_reg && !start;

endmodule

[hdl/rtnh_datapath.sv]
// Six fixed-point product lanes, saturating adders and the divider.
module rtnh_datapath
    import rtnh_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int TAG_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rtnh_pkg::dp_cmd_t            cmd,
    output rtnh_pkg::dp_status_t         status,
    input  logic signed [COORD_BITS-1:0] in_a [3],
    input  logic signed [COORD_BITS-1:0] in_b [3],
    input  logic signed [COORD_BITS-1:0] in_c [3],
    input  logic [TAG_BITS-1:0]          in_tag,
    input  logic signed [COORD_BITS-1:0] org [3],
    input  logic signed [COORD_BITS-1:0] dir [3],
    input  logic                         segment_only,
    input  logic [TOL_BITS-1:0]          tolerance,
    output logic                         out_found,
    output logic signed [COORD_BITS-1:0] out_t,
    output logic signed [COORD_BITS-1:0] out_p [3],
    output logic [TAG_BITS-1:0]          out_tag
);
    localparam int W  = COORD_BITS;
    localparam int PW = 2 * COORD_BITS;
    localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] QONE = W'(1) << FRAC_BITS;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W+1:0] v);
        if (v > (W+2)'(QMAX))
            return QMAX;
        else if (v < (W+2)'(QMIN))
            return QMIN;
        else
            return v[W-1:0];
    endfunction

    logic signed [W-1:0] e1_reg [3], e2_reg [3], s_reg [3];
    logic signed [W-1:0] h_reg [3], q_reg [3];
    logic signed [W-1:0] pa_reg [3], pb_reg [3];
    logic signed [W-1:0] det_reg, num_reg, u_reg;
    logic [TAG_BITS-1:0] tag_reg, best_tag_reg;
    logic signed [W-1:0] best_t_reg;
    logic                have_hit_reg;
    logic signed [W-1:0] op_x [6], op_y [6];
    logic signed [W-1:0] prod [6];
    logic signed [W-1:0] dot3;
    logic signed [W-1:0] quot;
    logic                div_done;
    logic [W:0]          det_mag;
    logic signed [W+1:0] uv;

    // Operand routing for six product lanes.
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            op_x[k] = '0;
            op_y[k] = '0;
        end
        case (cmd.op)
            OP_PROD_H, OP_PROD_Q:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    op_x[2*k]   = (cmd.op == OP_PROD_H) ? dir[(k+1)%3] : s_reg[(k+1)%3];
                    op_y[2*k]   = (cmd.op == OP_PROD_H) ? e2_reg[(k+2)%3] : e1_reg[(k+2)%3];
                    op_x[2*k+1] = (cmd.op == OP_PROD_H) ? dir[(k+2)%3] : s_reg[(k+2)%3];
                    op_y[2*k+1] = (cmd.op == OP_PROD_H) ? e2_reg[(k+1)%3] : e1_reg[(k+1)%3];
                end
            end
            OP_PROD_DET:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    op_x[k] = e1_reg[k];
                    op_y[k] = h_reg[k];
                end
            end
            OP_PROD_N:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    case (cmd.num_sel)
                        NUM_U:   begin op_x[k] = s_reg[k];  op_y[k] = h_reg[k]; end
                        NUM_V:   begin op_x[k] = dir[k];    op_y[k] = q_reg[k]; end
                        default: begin op_x[k] = e2_reg[k]; op_y[k] = q_reg[k]; end
                    endcase
                end
            end
            OP_PROD_P:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    op_x[k] = dir[k];
                    op_y[k] = best_t_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Q-format product: exact, floor shift, saturate.
    always_comb
    begin
        logic signed [PW-1:0] full;
        logic signed [PW-1:0] shf;
        for (int k = 0; k < 6; k++)
        begin
            full = PW'(op_x[k]) * PW'(op_y[k]);
            shf  = full >>> FRAC_BITS;
            if (shf > PW'(QMAX))
                prod[k] = QMAX;
            else if (shf < PW'(QMIN))
                prod[k] = QMIN;
            else
                prod[k] = shf[W-1:0];
        end
    end

    assign dot3 = sat_add((W+2)'(pa_reg[0]) + (W+2)'(pa_reg[1]) + (W+2)'(pa_reg[2]));
    assign det_mag = det_reg[W-1] ? (W+1)'(-$signed({det_reg[W-1], det_reg}))
                                  : (W+1)'(det_reg);
    assign uv = (W+2)'(u_reg) + (W+2)'(quot);

    rtnh_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_START),
        .num   (num_reg),
        .den   (det_reg),
        .done  (div_done),
        .quot  (quot)
    );

    always_comb
    begin
        status.det_ok   = det_mag > (W+1)'(tolerance);
        status.u_ok     = !quot[W-1] && quot <= QONE;
        status.v_ok     = !quot[W-1] && uv <= (W+2)'(QONE);
        status.div_done = div_done;
    end

    // Only the t quotient competes for nearest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_hit_reg <= 1'b0;
            best_t_reg   <= '0;
            best_tag_reg <= '0;
        end
        else if (cmd.op == OP_KEEP && cmd.num_sel == NUM_T)
        begin
            if (quot > 0 && (!have_hit_reg || quot < best_t_reg))
            begin
                have_hit_reg <= 1'b1;
                best_t_reg   <= quot;
                best_tag_reg <= tag_reg;
            end
        end
        else if (cmd.op == OP_EMIT)
        begin
            have_hit_reg <= 1'b0;
            best_t_reg   <= '0;
            best_tag_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_reg[k] <= sat_add((W+2)'(in_b[k]) - (W+2)'(in_a[k]));
                    e2_reg[k] <= sat_add((W+2)'(in_c[k]) - (W+2)'(in_a[k]));
                    s_reg[k]  <= sat_add((W+2)'(org[k]) - (W+2)'(in_a[k]));
                end
                tag_reg <= in_tag;
            end
            OP_PROD_H, OP_PROD_Q, OP_PROD_DET, OP_PROD_N, OP_PROD_P:
            begin
                if (cmd.op == OP_PROD_H || cmd.op == OP_PROD_Q)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        pa_reg[k] <= prod[2*k];
                        pb_reg[k] <= prod[2*k+1];
                    end
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                        pa_reg[k] <= prod[k];
                end
            end
            OP_CROSS_H:
                for (int k = 0; k < 3; k++)
                    h_reg[k] <= sat_add((W+2)'(pa_reg[k]) - (W+2)'(pb_reg[k]));
            OP_CROSS_Q:
                for (int k = 0; k < 3; k++)
                    q_reg[k] <= sat_add((W+2)'(pa_reg[k]) - (W+2)'(pb_reg[k]));
            OP_DOT_DET:
                det_reg <= dot3;
            OP_DOT_N:
                num_reg <= dot3;
            OP_KEEP:
                if (cmd.num_sel == NUM_U)
                    u_reg <= quot;
            OP_EMIT:
            begin
                out_found <= have_hit_reg && !(segment_only && best_t_reg > QONE);
                if (have_hit_reg && !(segment_only && best_t_reg > QONE))
                begin
                    out_t   <= best_t_reg;
                    out_tag <= best_tag_reg;
                    for (int k = 0; k < 3; k++)
                        out_p[k] <= sat_add((W+2)'(org[k]) + (W+2)'(pa_reg[k]));
                end
                else
                begin
                    out_t   <= '0;
                    out_tag <= '0;
                    for (int k = 0; k < 3; k++)
                        out_p[k] <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hdl/rtnh_ctrl.sv]
// Sequencer: walks one triangle through products, dots and up to three divisions.
module rtnh_ctrl
    import rtnh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_final,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rtnh_pkg::dp_cmd_t    cmd,
    input  rtnh_pkg::dp_status_t status
);
    state_t     state_reg, state_next;
    num_sel_t   sel_reg, sel_next;
    logic       final_reg, final_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        final_next = final_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    state_next = ST_PROD_H;
                    final_next = in_final;
                    sel_next   = NUM_U;
                end
            ST_PROD_H:    state_next = ST_CROSS_H;
            ST_CROSS_H:   state_next = ST_PROD_DET;
            ST_PROD_DET:  state_next = ST_DOT_DET;
            ST_DOT_DET:   state_next = ST_PROD_Q;
            ST_PROD_Q:    state_next = ST_CROSS_Q;
            ST_CROSS_Q:   state_next = ST_PROD_N;
            ST_PROD_N:    state_next = status.det_ok ? ST_DOT_N : ST_PROD_P;
            ST_DOT_N:     state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (status.div_done)
                    state_next = ST_KEEP;
            ST_KEEP:
            begin
                if (sel_reg == NUM_U && status.u_ok)
                begin
                    sel_next   = NUM_V;
                    state_next = ST_PROD_N;
                end
                else if (sel_reg == NUM_V && status.v_ok)
                begin
                    sel_next   = NUM_T;
                    state_next = ST_PROD_N;
                end
                else
                begin
                    state_next = ST_PROD_P;
                end
            end
            ST_PROD_P:    state_next = final_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:      state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op      = OP_NONE;
        cmd.num_sel = sel_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            ST_PROD_H:    cmd.op = OP_PROD_H;
            ST_CROSS_H:   cmd.op = OP_CROSS_H;
            ST_PROD_DET:  cmd.op = OP_PROD_DET;
            ST_DOT_DET:   cmd.op = OP_DOT_DET;
            ST_PROD_Q:    cmd.op = OP_PROD_Q;
            ST_CROSS_Q:   cmd.op = OP_CROSS_Q;
            ST_PROD_N:    cmd.op = status.det_ok ? OP_PROD_N : OP_NONE;
            ST_DOT_N:     cmd.op = OP_DOT_N;
            ST_DIV_START: cmd.op = OP_DIV_START;
            ST_KEEP:      cmd.op = (sel_reg == NUM_T) ? OP_KEEP : OP_NONE;
            ST_PROD_P:    cmd.op = OP_PROD_P;
            ST_EMIT:      cmd.op = OP_EMIT;
            ST_OUT:       out_valid = 1'b1;
            default:      cmd.op = OP_NONE;
        endcase
        // latch u on its KEEP step too
        if (state_reg == ST_KEEP && sel_reg == NUM_U)
            cmd.op = OP_KEEP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= NUM_U;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            final_reg <= final_next;
        end
    end

endmodule

[hdl/ray_triangle_nearest_hit.sv]
// Nearest ray-triangle hit. Load the ray and options through the cfg port while
// idle, then stream triangles on the triangle port; the one flagged final_triangle
// produces a single item on hit (found, nearest_t, hit point, tag) and clears the
// running nearest. One triangle is taken at a time. After the accept step, a
// triangle passes through the h products and cross, the determinant products and
// dot, and the q products and cross to reach the determinant check, then through
// up to three divisions (u, v, t) on the bit-serial divider, then the hit point
// product; a parallel triangle skips the divisions. A final triangle adds the
// emit step plus the wait on hit.ready.
module ray_triangle_nearest_hit
    import rtnh_pkg::*;
#(
    parameter int COORD_BITS = rtnh_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rtnh_pkg::FRAC_BITS_DEF,
    parameter int TAG_BITS   = rtnh_pkg::TAG_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rtnh_cfg_if.sink   cfg,
    rtnh_tri_if.sink   triangle,
    rtnh_hit_if.source hit
);
    localparam int W = COORD_BITS;

    logic signed [W-1:0] org_reg [3];
    logic signed [W-1:0] dir_reg [3];
    logic                seg_reg;
    logic [TOL_BITS-1:0] tol_reg;
    logic signed [W-1:0] va [3], vb [3], vc [3];
    logic signed [W-1:0] pt [3];
    dp_cmd_t             cmd;
    dp_status_t          status;

    assign cfg.ready = 1'b1;

    // Register file; the user must write only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
                org_reg[k] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= W'(1) << FRAC_BITS;
            seg_reg    <= 1'b0;
            tol_reg    <= TOL_BITS'(1);
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_ORIGIN_X:  org_reg[0] <= cfg.data[W-1:0];
                REG_ORIGIN_Y:  org_reg[1] <= cfg.data[W-1:0];
                REG_ORIGIN_Z:  org_reg[2] <= cfg.data[W-1:0];
                REG_DIR_X:     dir_reg[0] <= cfg.data[W-1:0];
                REG_DIR_Y:     dir_reg[1] <= cfg.data[W-1:0];
                REG_DIR_Z:     dir_reg[2] <= cfg.data[W-1:0];
                REG_SEGMENT:   seg_reg    <= cfg.data[0];
                REG_TOLERANCE: tol_reg    <= cfg.data[TOL_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign va = '{triangle.a_x, triangle.a_y, triangle.a_z};
    assign vb = '{triangle.b_x, triangle.b_y, triangle.b_z};
    assign vc = '{triangle.c_x, triangle.c_y, triangle.c_z};

    rtnh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (triangle.valid),
        .in_ready  (triangle.ready),
        .in_final  (triangle.final_triangle),
        .out_valid (hit.valid),
        .out_ready (hit.ready),
        .cmd       (cmd),
        .status    (status)
    );

    rtnh_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_a         (va),
        .in_b         (vb),
        .in_c         (vc),
        .in_tag       (triangle.tri_tag),
        .org          (org_reg),
        .dir          (dir_reg),
        .segment_only (seg_reg),
        .tolerance    (tol_reg),
        .out_found    (hit.found),
        .out_t        (hit.nearest_t),
        .out_p        (pt),
        .out_tag      (hit.nearest_tag)
    );

    assign hit.point_x = pt[0];
    assign hit.point_y = pt[1];
    assign hit.point_z = pt[2];

endmodule
